>>> rtl/spr_pkg.sv
// Shared types, constants and helpers of the servo packet receiver/responder.
package spr_pkg;

	// Largest parameter count that a received packet may carry
	localparam int MAX_PARAMS = 127;
	// Default depth of the reply request queue
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] SYNC_BYTE    = 8'hFF;
	localparam logic [7:0] BROADCAST_ID = 8'hFE;
	localparam logic [7:0] REPLY_LENGTH = 8'h02;
	localparam logic [7:0] LEN_MIN      = 8'h02;
	localparam logic [7:0] LEN_MAX      = 8'(MAX_PARAMS + 2);
	localparam logic [7:0] OWN_ID_RESET = 8'h01;

	// Error bits of the status reply
	localparam logic [7:0] ERR_NONE        = 8'h00;
	localparam logic [7:0] ERR_CHECKSUM    = 8'h10;
	localparam logic [7:0] ERR_INSTRUCTION = 8'h40;

	// Instruction codes
	localparam logic [7:0] INS_PING      = 8'h01;
	localparam logic [7:0] INS_LAST_STD  = 8'h06;
	localparam logic [7:0] INS_SYNC_WR   = 8'h83;
	localparam logic [7:0] INS_BULK_RD   = 8'h92;

	// Byte positions inside a status reply
	localparam logic [2:0] POS_SYNC0 = 3'd0;
	localparam logic [2:0] POS_SYNC1 = 3'd1;
	localparam logic [2:0] POS_ID    = 3'd2;
	localparam logic [2:0] POS_LEN   = 3'd3;
	localparam logic [2:0] POS_ERR   = 3'd4;
	localparam logic [2:0] POS_CSUM  = 3'd5;

	// Reply request from the framer to the queue
	typedef struct packed {
		logic       push;
		logic [7:0] err;
	} req_t;

	// Queue status toward the top-level rx stall and the reply sender
	typedef struct packed {
		logic       full;
		logic       empty;
		logic [7:0] err;
	} qstat_t;

	function automatic logic instruction_known(input logic [7:0] ins);
		instruction_known = (ins >= INS_PING && ins <= INS_LAST_STD) ||
			ins == INS_SYNC_WR || ins == INS_BULK_RD;
	endfunction

endpackage

>>> rtl/servo_packet_receiver_responder.sv
// Top level of the servo packet receiver and status responder.
// Takes one received byte per cycle on the rx channel and frames packets of the form
// FF FF id len ins params csum. A packet with a bad checksum or unknown instruction,
// or a ping to own_id or the broadcast id, queues a six-byte status reply
// (FF FF own_id 02 err csum, tx_last on csum) sent on the tx channel from an output
// register, one byte per cycle while tx_stall is low. rx takes an item every cycle
// unless the reply queue (QUEUE_DEPTH entries) is full. own_id resets to 1; the user
// writes it via cfg_we/cfg_wdata only while the block is idle; this is not checked.
module servo_packet_receiver_responder #(
	parameter int QUEUE_DEPTH = spr_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       tx_valid,
	input  logic       tx_stall,
	output logic [7:0] tx_byte,
	output logic       tx_last
);

	logic            [7:0] own_id_q;
	logic                  rx_accept;
	logic                  pop;
	spr_pkg::req_t         req;
	spr_pkg::qstat_t       stat;

	// Device id register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= spr_pkg::OWN_ID_RESET;
		end else if (cfg_we) begin
			own_id_q <= cfg_wdata;
		end
	end

	assign rx_stall  = stat.full;
	assign rx_accept = rx_valid && !rx_stall;

	spr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_accept (rx_accept),
		.rx_byte   (rx_byte),
		.own_id    (own_id_q),
		.req       (req)
	);

	spr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pop    (pop),
		.stat   (stat)
	);

	spr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.own_id   (own_id_q),
		.pop      (pop),
		.tx_valid (tx_valid),
		.tx_stall (tx_stall),
		.tx_byte  (tx_byte),
		.tx_last  (tx_last)
	);

endmodule

>>> rtl/spr_front.sv
// Packet framer: hunts the preamble, checks length, instruction and checksum, requests replies.
module spr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rx_accept,
	input  logic [7:0]       rx_byte,
	input  logic [7:0]       own_id,
	output spr_pkg::req_t    req
);

	typedef enum logic [2:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_ID,
		PH_LEN,
		PH_INS,
		PH_PARAM,
		PH_CSUM
	} phase_t;

	phase_t     phase_q;
	logic [7:0] id_q;
	logic [7:0] ins_q;
	logic [7:0] sum_q;
	logic [7:0] left_q;
	logic [7:0] err;
	logic       ping_hit;

	// Judge the packet against the checksum byte now on the input
	always_comb begin
		err = spr_pkg::instruction_known(ins_q) ? spr_pkg::ERR_NONE
			: spr_pkg::ERR_INSTRUCTION;
		if (~sum_q != rx_byte) begin
			err = err | spr_pkg::ERR_CHECKSUM;
		end
		ping_hit = ins_q == spr_pkg::INS_PING &&
			(id_q == own_id || id_q == spr_pkg::BROADCAST_ID);
	end

	assign req.push = rx_accept && phase_q == PH_CSUM &&
		(err != spr_pkg::ERR_NONE || ping_hit);
	assign req.err  = err;

	// Framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			id_q    <= '0;
			ins_q   <= '0;
			sum_q   <= '0;
			left_q  <= '0;
		end else if (rx_accept) begin
			case (phase_q)
				PH_HUNT1: begin
					phase_q <= (rx_byte == spr_pkg::SYNC_BYTE) ? PH_HUNT2 : PH_HUNT1;
				end
				PH_HUNT2: begin
					phase_q <= (rx_byte == spr_pkg::SYNC_BYTE) ? PH_ID : PH_HUNT1;
				end
				PH_ID: begin
					id_q    <= rx_byte;
					sum_q   <= rx_byte;
					phase_q <= PH_LEN;
				end
				PH_LEN: begin
					if (rx_byte < spr_pkg::LEN_MIN || rx_byte > spr_pkg::LEN_MAX) begin
						phase_q <= PH_HUNT1;
					end else begin
						sum_q   <= sum_q + rx_byte;
						left_q  <= rx_byte - spr_pkg::LEN_MIN;
						phase_q <= PH_INS;
					end
				end
				PH_INS: begin
					ins_q   <= rx_byte;
					sum_q   <= sum_q + rx_byte;
					phase_q <= (left_q != '0) ? PH_PARAM : PH_CSUM;
				end
				PH_PARAM: begin
					sum_q  <= sum_q + rx_byte;
					left_q <= left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_q <= PH_CSUM;
					end
				end
				PH_CSUM: begin
					phase_q <= PH_HUNT1;
				end
				default: begin
					phase_q <= PH_HUNT1;
				end
			endcase
		end
	end

	// Parameter phase always has at least one byte still to come
	a_param_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PARAM |-> left_q != '0)
		else $error("parameter phase with no bytes left");

	// A request always returns the framer to hunting
	a_push_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		req.push |=> phase_q == PH_HUNT1)
		else $error("framer not hunting after a reply request");

endmodule

>>> rtl/spr_queue.sv
// Small FIFO of pending reply error codes between framer and reply sender.
module spr_queue #(
	parameter int DEPTH = spr_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  spr_pkg::req_t   req,
	input  logic            pop,
	output spr_pkg::qstat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [7:0]       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = count_q == CNT_W'(DEPTH);
	assign stat.empty = count_q == '0;
	assign stat.err   = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (req.push) begin
			mem_q[wr_ptr_q] <= req.err;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (req.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (req.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !req.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		req.push && !pop |-> !stat.full)
		else $error("reply queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("reply queue underflow");

endmodule

>>> rtl/spr_back.sv
// Reply sender: turns queued error codes into six-byte status replies.
module spr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  spr_pkg::qstat_t stat,
	input  logic [7:0]      own_id,
	output logic            pop,
	output logic            tx_valid,
	input  logic            tx_stall,
	output logic [7:0]      tx_byte,
	output logic            tx_last
);

	logic       active_q;
	logic [2:0] pos_q;
	logic [7:0] err_q;
	logic       tx_valid_q;
	logic [7:0] tx_byte_q;
	logic       tx_last_q;
	logic       load;
	logic [7:0] next_byte;

	assign load     = !tx_valid_q || !tx_stall;
	assign pop      = load && !active_q && !stat.empty;
	assign tx_valid = tx_valid_q;
	assign tx_byte  = tx_byte_q;
	assign tx_last  = tx_last_q;

	// Reply byte at the current position
	always_comb begin
		case (pos_q)
			spr_pkg::POS_SYNC0: next_byte = spr_pkg::SYNC_BYTE;
			spr_pkg::POS_SYNC1: next_byte = spr_pkg::SYNC_BYTE;
			spr_pkg::POS_ID:    next_byte = own_id;
			spr_pkg::POS_LEN:   next_byte = spr_pkg::REPLY_LENGTH;
			spr_pkg::POS_ERR:   next_byte = err_q;
			spr_pkg::POS_CSUM:  next_byte = ~(own_id + spr_pkg::REPLY_LENGTH + err_q);
			default:            next_byte = spr_pkg::SYNC_BYTE;
		endcase
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			pos_q      <= spr_pkg::POS_SYNC0;
			err_q      <= '0;
			tx_valid_q <= 1'b0;
			tx_byte_q  <= '0;
			tx_last_q  <= 1'b0;
		end else if (load) begin
			if (active_q) begin
				tx_valid_q <= 1'b1;
				tx_byte_q  <= next_byte;
				tx_last_q  <= pos_q == spr_pkg::POS_CSUM;
				active_q   <= pos_q != spr_pkg::POS_CSUM;
				pos_q      <= pos_q + 3'd1;
			end else if (!stat.empty) begin
				// first sync byte goes out as the entry is taken
				tx_valid_q <= 1'b1;
				tx_byte_q  <= spr_pkg::SYNC_BYTE;
				tx_last_q  <= 1'b0;
				err_q      <= stat.err;
				active_q   <= 1'b1;
				pos_q      <= spr_pkg::POS_SYNC1;
			end else begin
				tx_valid_q <= 1'b0;
			end
		end
	end

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid_q && tx_last_q && !tx_stall |-> !active_q)
		else $error("sender still busy after the last reply byte");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> pos_q <= spr_pkg::POS_CSUM && pos_q != spr_pkg::POS_SYNC0)
		else $error("reply position out of range");

endmodule

>>> dv/testbench.sv
// Testbench for the servo packet receiver/responder: framing, error replies and ping replies.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int RANDOM_ITEMS  = 210;

	// Receive framing positions
	typedef enum logic [2:0] {
		F_HUNT0, F_HUNT1, F_ID, F_LEN, F_INS, F_PARAM, F_CSUM
	} frame_pos_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} reply_byte_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       rx_valid  = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte   = 8'h00;
	logic       tx_valid;
	logic       tx_stall  = 1'b0;
	logic [7:0] tx_byte;
	logic       tx_last;

	// Predicted framer state and register copy
	frame_pos_t fpos        = F_HUNT0;
	logic [7:0] own_id_cfg  = spr_pkg::OWN_ID_RESET;
	logic [7:0] rx_id       = 8'h00;
	logic [7:0] rx_ins      = 8'h00;
	logic [7:0] rx_sum      = 8'h00;
	logic [7:0] params_left = 8'h00;

	reply_byte_t status_reply_q[$];
	int          mismatches = 0;
	int          pkt_items  = 0;
	bit          rx_calm    = 1'b0;
	bit          tx_calm    = 1'b0;

	servo_packet_receiver_responder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.tx_valid (tx_valid),
		.tx_stall (tx_stall),
		.tx_byte  (tx_byte),
		.tx_last  (tx_last)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic bit is_known_ins(input logic [7:0] ins);
		return (ins >= spr_pkg::INS_PING && ins <= spr_pkg::INS_LAST_STD) ||
			ins == spr_pkg::INS_SYNC_WR || ins == spr_pkg::INS_BULK_RD;
	endfunction

	// Six-byte status reply: FF FF id 02 err csum
	function automatic void queue_status_reply(input logic [7:0] err);
		logic [7:0] csum;
		reply_byte_t rb;
		csum = own_id_cfg + spr_pkg::REPLY_LENGTH + err;
		csum = ~csum;
		rb = '{data: spr_pkg::SYNC_BYTE, last: 1'b0};
		status_reply_q.push_back(rb);
		status_reply_q.push_back(rb);
		rb.data = own_id_cfg;
		status_reply_q.push_back(rb);
		rb.data = spr_pkg::REPLY_LENGTH;
		status_reply_q.push_back(rb);
		rb.data = err;
		status_reply_q.push_back(rb);
		rb = '{data: csum, last: 1'b1};
		status_reply_q.push_back(rb);
	endfunction

	// Advance the predicted framer by one received byte
	function automatic void frame_rx_byte(input logic [7:0] b);
		logic [7:0] err;
		err = spr_pkg::ERR_NONE;
		case (fpos)
			F_HUNT0: fpos = (b == spr_pkg::SYNC_BYTE) ? F_HUNT1 : F_HUNT0;
			F_HUNT1: fpos = (b == spr_pkg::SYNC_BYTE) ? F_ID : F_HUNT0;
			F_ID: begin
				rx_id  = b;
				rx_sum = b;
				fpos   = F_LEN;
			end
			F_LEN: begin
				if (b < spr_pkg::LEN_MIN || b > spr_pkg::LEN_MAX) begin
					fpos = F_HUNT0;
				end else begin
					rx_sum      = rx_sum + b;
					params_left = b - spr_pkg::LEN_MIN;
					fpos        = F_INS;
				end
			end
			F_INS: begin
				rx_ins = b;
				rx_sum = rx_sum + b;
				fpos   = (params_left != 8'h00) ? F_PARAM : F_CSUM;
			end
			F_PARAM: begin
				rx_sum      = rx_sum + b;
				params_left = params_left - 8'd1;
				if (params_left == 8'h00) fpos = F_CSUM;
			end
			F_CSUM: begin
				fpos = F_HUNT0;
				if (!is_known_ins(rx_ins)) err = err | spr_pkg::ERR_INSTRUCTION;
				if (~rx_sum != b) err = err | spr_pkg::ERR_CHECKSUM;
				if (err != spr_pkg::ERR_NONE || (rx_ins == spr_pkg::INS_PING &&
						(rx_id == own_id_cfg || rx_id == spr_pkg::BROADCAST_ID)))
					queue_status_reply(err);
			end
			default: fpos = F_HUNT0;
		endcase
	endfunction

	// Checker of reply bytes and predictor feed, sampled at the edge
	always @(posedge clk) begin
		reply_byte_t want;
		if (arst_n) begin
			if (tx_valid && !tx_stall) begin
				if (status_reply_q.size() == 0) begin
					report_mismatch($sformatf("unexpected tx item %02h last %0b",
						tx_byte, tx_last));
				end else begin
					want = status_reply_q.pop_front();
					if (tx_byte !== want.data)
						report_mismatch($sformatf("tx_byte %02h, want %02h",
							tx_byte, want.data));
					if (tx_last !== want.last)
						report_mismatch($sformatf("tx_last %0b, want %0b",
							tx_last, want.last));
				end
			end
			if (rx_valid && !rx_stall) frame_rx_byte(rx_byte);
		end
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// Receiver back-pressure on the reply side
	initial begin
		int run;
		int len;
		wait (arst_n);
		forever begin
			if (tx_calm) begin
				tx_stall <= 1'b0;
				@(posedge clk);
			end else begin
				run = $urandom_range(1, 12);
				tx_stall <= 1'b0;
				repeat (run) @(posedge clk);
				len = $urandom_range(0, 99);
				if (len < 70) len = $urandom_range(1, 2);
				else if (len < 92) len = $urandom_range(3, 8);
				else len = $urandom_range(15, 60);
				tx_stall <= 1'b1;
				repeat (len) @(posedge clk);
			end
		end
	end

	// Send one received byte; returns at the edge where it is taken
	task automatic send_rx(input logic [7:0] b);
		int gap;
		gap = rx_calm ? 0 : pick_gap();
		if (gap != 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (rx_stall) @(posedge clk);
		pkt_items++;
	endtask

	// Full packet; an out-of-range length stops after the length byte
	task automatic send_packet(input logic [7:0] id, input logic [7:0] len,
			input logic [7:0] ins, input bit bad_csum);
		logic [7:0] sum;
		logic [7:0] p;
		int n;
		send_rx(spr_pkg::SYNC_BYTE);
		send_rx(spr_pkg::SYNC_BYTE);
		send_rx(id);
		send_rx(len);
		if (len < spr_pkg::LEN_MIN || len > spr_pkg::LEN_MAX) return;
		sum = id + len;
		sum = sum + ins;
		send_rx(ins);
		for (n = 0; n < int'(len) - 2; n++) begin
			p = 8'($urandom_range(0, 255));
			sum = sum + p;
			send_rx(p);
		end
		sum = ~sum;
		if (bad_csum) sum = sum ^ 8'($urandom_range(1, 255));
		send_rx(sum);
	endtask

	// Hold the sender until every predicted reply byte is out, then settle
	task automatic drain_replies();
		int k;
		rx_valid <= 1'b0;
		@(posedge clk);
		for (k = 0; k < DRAIN_LIMIT && status_reply_q.size() != 0; k++) @(posedge clk);
		if (status_reply_q.size() != 0) begin
			report_mismatch($sformatf("%0d reply items never came",
				status_reply_q.size()));
			status_reply_q.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_own_id(input logic [7:0] v);
		drain_replies();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		own_id_cfg = v;
	endtask

	function automatic logic [7:0] pick_known_ins();
		int r;
		r = $urandom_range(0, 7);
		if (r < 6) return spr_pkg::INS_PING + 8'(r);
		return (r == 6) ? spr_pkg::INS_SYNC_WR : spr_pkg::INS_BULK_RD;
	endfunction

	function automatic logic [7:0] pick_unknown_ins();
		logic [7:0] v;
		do v = 8'($urandom_range(0, 255)); while (is_known_ins(v));
		return v;
	endfunction

	function automatic logic [7:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return 8'($urandom_range(2, 6));
		if (r < 99) return 8'($urandom_range(7, 20));
		return 8'($urandom_range(30, int'(spr_pkg::LEN_MAX)));
	endfunction

	// Edge cases at the reset own_id
	task automatic test_directed_frames();
		send_packet(spr_pkg::OWN_ID_RESET, spr_pkg::LEN_MIN, spr_pkg::INS_PING, 1'b0);
		// broken preamble
		send_rx(spr_pkg::SYNC_BYTE);
		send_rx(8'h00);
		send_packet(8'h05, 8'h01, spr_pkg::INS_PING, 1'b0);
		send_packet(8'h05, spr_pkg::LEN_MAX + 8'd1, spr_pkg::INS_PING, 1'b0);
		// ID byte FF, unknown instruction and bad checksum together
		send_packet(8'hFF, spr_pkg::LEN_MIN, 8'h00, 1'b1);
		send_packet(8'h20, spr_pkg::LEN_MIN, spr_pkg::INS_PING, 1'b0);
	endtask

	// Addressing at the own_id extremes, outside range and equal to broadcast
	task automatic test_own_id_settings();
		logic [7:0] ids[5];
		int k;
		ids[0] = 8'h00;
		ids[1] = 8'hFD;
		ids[2] = 8'hFF;
		ids[3] = spr_pkg::BROADCAST_ID;
		ids[4] = 8'($urandom_range(0, 255));
		for (k = 0; k < 5; k++) begin
			set_own_id(ids[k]);
			send_packet(ids[k], spr_pkg::LEN_MIN, spr_pkg::INS_PING, 1'b0);
			send_packet(spr_pkg::BROADCAST_ID, 8'd3, spr_pkg::INS_PING, 1'b0);
			send_packet(ids[k] ^ 8'h01, spr_pkg::LEN_MIN, spr_pkg::INS_PING, 1'b0);
			send_packet(ids[k], spr_pkg::LEN_MIN, spr_pkg::INS_LAST_STD, 1'b0);
		end
	endtask

	// Mostly well-formed packets with random content, plus noise and broken frames
	task automatic test_random_traffic();
		int start;
		int r;
		int n;
		int next_phase;
		bit paused;
		logic [7:0] v;
		start      = pkt_items;
		next_phase = start + 90;
		paused     = 1'b0;
		send_packet(own_id_cfg, spr_pkg::LEN_MAX, spr_pkg::INS_PING, 1'b0);
		while (pkt_items - start < RANDOM_ITEMS) begin
			// new own_id between phases
			if (pkt_items >= next_phase) begin
				next_phase += 90;
				r = $urandom_range(0, 4);
				v = (r == 0) ? 8'h00 : (r == 1) ? 8'hFD : (r == 2) ? 8'hFF :
					8'($urandom_range(0, 255));
				set_own_id(v);
			end
			// sender holds off until all replies are out
			if (!paused && pkt_items - start >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				drain_replies();
			end else if ($urandom_range(0, 99) < 3) begin
				drain_replies();
			end
			if ($urandom_range(0, 9) == 0) rx_calm = !rx_calm;
			if ($urandom_range(0, 9) == 0) tx_calm = !tx_calm;
			r = $urandom_range(0, 99);
			if (r < 10) begin
				for (n = $urandom_range(1, 4); n > 0; n--)
					send_rx(($urandom_range(0, 7) == 0) ? spr_pkg::SYNC_BYTE :
						8'($urandom_range(0, 254)));
			end else if (r < 16) begin
				v = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1)) :
					8'($urandom_range(int'(spr_pkg::LEN_MAX) + 1, 255));
				send_packet(8'($urandom_range(0, 255)), v, spr_pkg::INS_PING, 1'b0);
			end else if (r < 30) begin
				send_packet(own_id_cfg, pick_len(), spr_pkg::INS_PING, 1'b0);
			end else if (r < 36) begin
				send_packet(spr_pkg::BROADCAST_ID, pick_len(), spr_pkg::INS_PING, 1'b0);
			end else if (r < 42) begin
				send_packet(8'($urandom_range(0, 255)), pick_len(), spr_pkg::INS_PING,
					1'b0);
			end else if (r < 62) begin
				send_packet(8'($urandom_range(0, 255)), pick_len(), pick_known_ins(),
					1'b0);
			end else if (r < 78) begin
				send_packet(8'($urandom_range(0, 255)), pick_len(), pick_unknown_ins(),
					1'($urandom_range(0, 1)));
			end else begin
				send_packet(8'($urandom_range(0, 255)), pick_len(), pick_known_ins(),
					1'b1);
			end
		end
		rx_calm = 1'b0;
		tx_calm = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_own_id_settings();
		test_random_traffic();
		drain_replies();
		if (mismatches == 0)
			$display("servo_packet_receiver_responder regression: pass");
		else
			$display("servo_packet_receiver_responder regression: fail");
		$finish;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("servo_packet_receiver_responder regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
rtl/spr_pkg.sv
rtl/spr_front.sv
rtl/spr_queue.sv
rtl/spr_back.sv
rtl/servo_packet_receiver_responder.sv
dv/testbench.sv
